FILE: rtl/core/qesd_pkg.sv
`timescale 1ns / 1ps

package qesd_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_EDGE_A = 2'd0;
    localparam logic [1:0] OP_EDGE_B = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_IDX_THRESHOLD = 2'd1;

    // Configuration reset values
    localparam logic [19:0] INTERVAL_RESET  = 20'd10000;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd5;

    // Speed arithmetic
    localparam int unsigned   NUM_W       = 43;
    localparam logic [26:0]   PULSE_SCALE = 27'd1000;
    localparam logic [42:0]   NUM_FAR     = 43'd65536000;
    localparam logic [15:0]   COUNT_MAX   = 16'hFFFF;
    localparam logic [31:0]   SPEED_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0]   SPEED_MAX_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_EDGE_A = 2'd0,
        KIND_EDGE_B = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] time_us;
    } entry_t;

    typedef struct packed {
        logic [19:0] update_interval_us;
        logic [7:0]  direction_threshold;
    } cfg_t;

endpackage

FILE: rtl/core/quadrature_encoder_speed_direction_core.sv
`timescale 1ns / 1ps
// Edge items retire one per cycle through the queue while no query is
// in progress. A query runs PREP, SETUP, DIV (a one-bit-a-cycle restoring
// divider) and DONE; edges queue behind it until its result is registered.
// aresetn is synchronous, active low: control and edge state clear to
// zero, direction positive, interval 10000 us, threshold 5; payload and
// queue storage registers are not reset. No clearing pass is needed.
module quadrature_encoder_speed_direction_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] time_us
    input  logic [1:0]  s_tuser,     // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] speed
    output logic        m_tuser,     // [0] reverse
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    qesd_pkg::cfg_t   cfg_reg;
    qesd_pkg::entry_t push_entry;
    qesd_pkg::entry_t head;
    logic             push, pop, queue_full, queue_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_interval_us  <= qesd_pkg::INTERVAL_RESET;
            cfg_reg.direction_threshold <= qesd_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                qesd_pkg::CFG_IDX_INTERVAL:  cfg_reg.update_interval_us  <= cfg_data;
                qesd_pkg::CFG_IDX_THRESHOLD: cfg_reg.direction_threshold <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    qesd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    qesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    qesd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (queue_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/qesd_front.sv
`timescale 1ns / 1ps

module qesd_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,     // [31:0] time_us
    input  logic [1:0]           s_tuser,     // [1:0] operation
    input  logic                 queue_full,
    output logic                 push,
    output qesd_pkg::entry_t     push_entry
);

    logic keep;

    // Accept whenever the queue has room
    assign s_tready = !queue_full;

    // Classify the operation; drop unused codes
    always_comb begin
        keep            = 1'b1;
        push_entry.kind = qesd_pkg::KIND_EDGE_A;
        case (s_tuser)
            qesd_pkg::OP_EDGE_A: push_entry.kind = qesd_pkg::KIND_EDGE_A;
            qesd_pkg::OP_EDGE_B: push_entry.kind = qesd_pkg::KIND_EDGE_B;
            qesd_pkg::OP_QUERY:  push_entry.kind = qesd_pkg::KIND_QUERY;
            default:             keep = 1'b0;
        endcase
        push_entry.time_us = s_tdata;
    end

    assign push = s_tvalid && !queue_full && keep;

endmodule

FILE: rtl/core/qesd_queue.sv
`timescale 1ns / 1ps

module qesd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  qesd_pkg::entry_t  push_entry,
    input  logic              pop,
    output qesd_pkg::entry_t  head,
    output logic              full,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qesd_pkg::entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at the last entry
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/qesd_back.sv
`timescale 1ns / 1ps

module qesd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  qesd_pkg::cfg_t    cfg,
    input  qesd_pkg::entry_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_DIV,
        S_DONE
    } state_t;

    localparam int unsigned BIT_W = $clog2(qesd_pkg::NUM_W);

    state_t      state_reg, state_next;
    // Architectural state
    logic [31:0] wst_reg, wst_next;
    logic [15:0] latched_reg, latched_next;
    logic [15:0] running_reg, running_next;
    logic [31:0] edge_a_reg, edge_a_next;
    logic [31:0] edge_b_reg, edge_b_next;
    logic [31:0] gap_a_reg, gap_a_next;
    logic        dir_reg, dir_next;
    logic [7:0]  cd_reg, cd_next;
    // Query working registers
    logic [31:0] t_reg, t_next;
    logic [31:0] d_reg, d_next;
    logic        inwin_reg, inwin_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [42:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic        divzero_reg, divzero_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic [15:0] run_inc;
    logic [31:0] win_age;
    logic [31:0] gap_b;
    logic        want_neg;
    logic [21:0] iv3;
    logic [26:0] scaled_cnt;
    logic [32:0] trial;
    logic [31:0] mag_sat;
    logic        out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pop      = (state_reg == S_IDLE) && !empty;
    assign out_free = !m_tvalid_reg || m_tready;

    // Edge arithmetic
    assign run_inc  = (running_reg == qesd_pkg::COUNT_MAX) ? running_reg
                                                           : running_reg + 16'd1;
    assign win_age  = head.time_us - wst_reg;
    assign gap_b    = head.time_us - edge_a_reg;
    assign want_neg = !(gap_a_reg > gap_b);

    // Query arithmetic
    assign iv3        = {2'b00, cfg.update_interval_us}
                      + {1'b0, cfg.update_interval_us, 1'b0};
    assign scaled_cnt = 27'(cnt_reg) * qesd_pkg::PULSE_SCALE;
    assign trial      = {rem_reg, num_reg[42]} - {1'b0, den_reg};

    // Saturate the magnitude for the current direction
    always_comb begin
        if (dir_reg) begin
            mag_sat = (divzero_reg || num_reg > 43'(qesd_pkg::SPEED_MAX_NEG))
                    ? qesd_pkg::SPEED_MAX_NEG : num_reg[31:0];
        end else begin
            mag_sat = (divzero_reg || num_reg > 43'(qesd_pkg::SPEED_MAX_POS))
                    ? qesd_pkg::SPEED_MAX_POS : num_reg[31:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        wst_next      = wst_reg;
        latched_next  = latched_reg;
        running_next  = running_reg;
        edge_a_next   = edge_a_reg;
        edge_b_next   = edge_b_reg;
        gap_a_next    = gap_a_reg;
        dir_next      = dir_reg;
        cd_next       = cd_reg;
        t_next        = t_reg;
        d_next        = d_reg;
        inwin_next    = inwin_reg;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        divzero_next  = divzero_reg;
        bit_cnt_next  = bit_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE: begin
                if (!empty) begin
                    case (head.kind)
                        qesd_pkg::KIND_EDGE_A: begin
                            // Count the pulse, close the window when due
                            edge_a_next = head.time_us;
                            gap_a_next  = head.time_us - edge_b_reg;
                            if (win_age > {12'd0, cfg.update_interval_us}) begin
                                wst_next     = head.time_us;
                                latched_next = run_inc;
                                running_next = '0;
                            end else begin
                                running_next = run_inc;
                            end
                        end
                        qesd_pkg::KIND_EDGE_B: begin
                            // Filter the direction reading
                            edge_b_next = head.time_us;
                            if (dir_reg == want_neg) begin
                                cd_next = cfg.direction_threshold;
                            end else if (cd_reg != 8'd0) begin
                                cd_next = cd_reg - 8'd1;
                            end else begin
                                dir_next = want_neg;
                                cd_next  = cfg.direction_threshold;
                            end
                        end
                        qesd_pkg::KIND_QUERY: begin
                            t_next     = head.time_us;
                            state_next = S_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP: begin
                // Window age, branch choice and total count
                d_next     = t_reg - wst_reg;
                inwin_next = ((t_reg - wst_reg) < {10'd0, iv3});
                cnt_next   = {1'b0, latched_reg} + {1'b0, running_reg};
                state_next = S_SETUP;
            end
            S_SETUP: begin
                // Load dividend and divisor
                if (inwin_reg) begin
                    num_next     = {scaled_cnt, 16'd0};
                    den_next     = {12'd0, cfg.update_interval_us} + d_reg;
                    divzero_next = 1'b0;
                end else begin
                    num_next     = qesd_pkg::NUM_FAR;
                    den_next     = d_reg;
                    divzero_next = (d_reg == 32'd0);
                end
                rem_next     = '0;
                bit_cnt_next = BIT_W'(qesd_pkg::NUM_W - 1);
                state_next   = S_DIV;
            end
            S_DIV: begin
                // One restoring step a cycle; quotient shifts into num
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                    num_next = {num_reg[41:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[30:0], num_reg[42]};
                    num_next = {num_reg[41:0], 1'b0};
                end
                if (bit_cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = dir_reg ? (32'd0 - mag_sat) : mag_sat;
                    m_tuser_next  = dir_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            wst_reg      <= '0;
            latched_reg  <= '0;
            running_reg  <= '0;
            edge_a_reg   <= '0;
            edge_b_reg   <= '0;
            gap_a_reg    <= '0;
            dir_reg      <= 1'b0;
            cd_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            wst_reg      <= wst_next;
            latched_reg  <= latched_next;
            running_reg  <= running_next;
            edge_a_reg   <= edge_a_next;
            edge_b_reg   <= edge_b_next;
            gap_a_reg    <= gap_a_next;
            dir_reg      <= dir_next;
            cd_reg       <= cd_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        d_reg       <= d_next;
        inwin_reg   <= inwin_next;
        cnt_reg     <= cnt_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        divzero_reg <= divzero_next;
        bit_cnt_reg <= bit_cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam logic [1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [1:0] CFG_IDX_SPARE3 = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 100;

    typedef struct {
        logic [31:0] speed;
        logic        reverse;
    } speed_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] time_us
    logic [1:0]  s_tuser = '0;      // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] speed
    logic        m_tuser;           // [0] reverse
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    // Predictor state: configuration and encoder tracking
    logic [19:0] reg_interval = qesd_pkg::INTERVAL_RESET;
    logic [7:0]  reg_threshold = qesd_pkg::THRESHOLD_RESET;
    logic [31:0] win_start = '0;
    logic [15:0] latched_cnt = '0;
    logic [15:0] running_cnt = '0;
    logic [31:0] a_edge_time = '0;
    logic [31:0] b_edge_time = '0;
    logic [31:0] a_after_b_gap = '0;
    logic        dir_negative = 1'b0;
    logic [7:0]  flip_countdown = '0;

    speed_result_t pending_speed_q[$];

    int          error_count = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    bit          no_gaps = 1'b0;
    logic [31:0] clock_us = '0;

    quadrature_encoder_speed_direction_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_draw();
        return no_gaps ? 0 : int'($urandom_range(0, 4));
    endfunction

    // Signed Q16.16 pulses per millisecond for a query at time t
    function automatic logic [31:0] expected_speed(input logic [31:0] t);
        logic [31:0] d;
        logic [63:0] iv;
        logic [63:0] cnt;
        logic [63:0] den;
        logic [63:0] mag;
        d = t - win_start;
        iv = {44'd0, reg_interval};
        if ({32'd0, d} < 3 * iv) begin
            cnt = {48'd0, latched_cnt} + {48'd0, running_cnt};
            den = iv + {32'd0, d};
            mag = (den == 0) ? '1 : (cnt * 64'd65536000) / den;
        end else begin
            mag = (d == 0) ? '1 : 64'd65536000 / {32'd0, d};
        end
        if (dir_negative) begin
            if (mag > {32'd0, qesd_pkg::SPEED_MAX_NEG}) mag = {32'd0, qesd_pkg::SPEED_MAX_NEG};
            return 32'd0 - mag[31:0];
        end
        if (mag > {32'd0, qesd_pkg::SPEED_MAX_POS}) mag = {32'd0, qesd_pkg::SPEED_MAX_POS};
        return mag[31:0];
    endfunction

    // Advance the encoder state for one accepted item; queue a result for queries
    task automatic track_encoder_event(input logic [1:0] op, input logic [31:0] t);
        logic [31:0]   b_after_a;
        logic          want_neg;
        speed_result_t r;
        case (op)
            qesd_pkg::OP_EDGE_A: begin
                a_edge_time = t;
                if (running_cnt != qesd_pkg::COUNT_MAX) running_cnt = running_cnt + 16'd1;
                a_after_b_gap = t - b_edge_time;
                if ((t - win_start) > {12'd0, reg_interval}) begin
                    win_start = t;
                    latched_cnt = running_cnt;
                    running_cnt = '0;
                end
            end
            qesd_pkg::OP_EDGE_B: begin
                b_edge_time = t;
                b_after_a = t - a_edge_time;
                want_neg = (a_after_b_gap > b_after_a) ? 1'b0 : 1'b1;
                // filter: flip only once the countdown has run out
                if (dir_negative == want_neg) begin
                    flip_countdown = reg_threshold;
                end else if (flip_countdown != 0) begin
                    flip_countdown = flip_countdown - 8'd1;
                end else begin
                    dir_negative = want_neg;
                    flip_countdown = reg_threshold;
                end
            end
            qesd_pkg::OP_QUERY: begin
                r.speed = expected_speed(t);
                r.reverse = dir_negative;
                pending_speed_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Track configuration writes and accepted items
    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_interval = qesd_pkg::INTERVAL_RESET;
            reg_threshold = qesd_pkg::THRESHOLD_RESET;
            win_start = '0;
            latched_cnt = '0;
            running_cnt = '0;
            a_edge_time = '0;
            b_edge_time = '0;
            a_after_b_gap = '0;
            dir_negative = 1'b0;
            flip_countdown = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    qesd_pkg::CFG_IDX_INTERVAL:  reg_interval = cfg_data;
                    qesd_pkg::CFG_IDX_THRESHOLD: reg_threshold = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) track_encoder_event(s_tuser, s_tdata);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin : check_result
        speed_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_speed_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result speed %h reverse %b",
                             $time, m_tdata, m_tuser);
            end else begin
                want = pending_speed_q.pop_front();
                if (m_tdata !== want.speed) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: speed expected %h actual %h",
                                 $time, want.speed, m_tdata);
                end
                if (m_tuser !== want.reverse) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: reverse expected %b actual %b",
                                 $time, want.reverse, m_tuser);
                end
            end
        end
    end

    // Stall the result side after results and now and then while idle
    always @(posedge aclk) begin : result_stall
        int n;
        n = idle_draw();
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (m_tready) begin
            if (m_tvalid || $urandom_range(0, 7) == 0) begin
                m_tready <= (n == 0);
                ready_hold <= n;
            end
        end else if (ready_hold > 1) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("quadrature_encoder_speed_direction_core verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] t);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid, drain all results, then let queued edges retire
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_speed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [19:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        repeat (1 + idle_draw()) @(posedge aclk);
    endtask

    task automatic set_config(input logic [19:0] iv_value, input logic [7:0] thr_value);
        wait_idle();
        write_register(qesd_pkg::CFG_IDX_INTERVAL, iv_value);
        // upper bits of the threshold write are don't-care
        write_register(qesd_pkg::CFG_IDX_THRESHOLD, {12'($urandom), thr_value});
    endtask

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(4, 40));
            1:       return 32'($urandom_range(40, 2000));
            2:       return 32'($urandom_range(2000, 60000));
            default: return 32'($urandom_range(4, 8));
        endcase
    endfunction

    function automatic logic [31:0] query_time();
        case ($urandom_range(0, 3))
            0:       return clock_us;
            1:       return clock_us + $urandom_range(0, 100000);
            2:       return win_start + 3 * {12'd0, reg_interval} + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    // Reset values: empty count, wrap of the window age, near and far branches
    task automatic test_reset_values();
        send_item(qesd_pkg::OP_QUERY, 32'd0);
        send_item(qesd_pkg::OP_QUERY, 32'hFFFF_FFFF);
        send_item(OP_RESERVED, 32'h5A5A_A5A5);
        send_item(qesd_pkg::OP_EDGE_A, 32'd0);
        send_item(qesd_pkg::OP_EDGE_A, 32'd10001);
        send_item(qesd_pkg::OP_QUERY, 32'd10001);
        send_item(qesd_pkg::OP_QUERY, 32'd40000);
        send_item(qesd_pkg::OP_QUERY, 32'd40001);
    endtask

    // Direction filter, zero interval and saturation in both directions
    task automatic test_direction_filter();
        int k;
        send_item(qesd_pkg::OP_EDGE_B, 32'd10100);
        send_item(qesd_pkg::OP_QUERY, 32'd10100);
        set_config(20'd10000, 8'd0);
        write_register(CFG_IDX_SPARE2, 20'hFFFFF);
        write_register(CFG_IDX_SPARE3, 20'h00000);
        send_item(qesd_pkg::OP_EDGE_A, 32'd20000);
        // a run of opposite readings drains the countdown, then flips
        for (k = 0; k < 6; k++) send_item(qesd_pkg::OP_EDGE_B, 32'd40000 + 32'(k * 10));
        send_item(qesd_pkg::OP_QUERY, 32'd40050);
        set_config(20'd0, 8'd0);
        send_item(qesd_pkg::OP_QUERY, 32'd10001);
        send_item(qesd_pkg::OP_EDGE_A, 32'd10001);
        send_item(qesd_pkg::OP_EDGE_A, 32'd10002);
        send_item(qesd_pkg::OP_QUERY, 32'd10002);
        send_item(qesd_pkg::OP_EDGE_B, 32'd10003);
        send_item(qesd_pkg::OP_QUERY, 32'd10002);
        send_item(qesd_pkg::OP_QUERY, 32'd10003);
    endtask

    // Pile A edges onto the window start, then probe the window limits
    task automatic test_count_saturation();
        logic [31:0] t0;
        int          k;
        set_config(20'd1000000, 8'd3);
        t0 = win_start;
        no_gaps = 1'b1;
        for (k = 0; k < 16; k++) send_item(qesd_pkg::OP_EDGE_A, t0);
        send_item(qesd_pkg::OP_QUERY, t0);
        send_item(qesd_pkg::OP_QUERY, t0 + 32'd2999999);
        send_item(qesd_pkg::OP_EDGE_A, t0 + 32'd1000001);
        send_item(qesd_pkg::OP_QUERY, t0 + 32'd1000001);
        no_gaps = 1'b0;
    endtask

    // One burst: mostly clean quadrature runs, some queries, noise and broken runs
    task automatic drive_traffic_burst();
        int          pick;
        int          n;
        int          k;
        logic [31:0] period;
        logic [31:0] lag;
        logic [1:0]  op;
        bit          backwards;
        pick = $urandom_range(0, 9);
        no_gaps = ($urandom_range(0, 5) == 0);
        if (pick < 7) begin
            n = $urandom_range(3, 30);
            backwards = 1'($urandom_range(0, 1));
            period = pick_period();
            for (k = 0; k < n; k++) begin
                lag = period / 4 + $urandom_range(0, period / 8);
                if (!backwards) begin
                    send_item(qesd_pkg::OP_EDGE_A, clock_us);
                    send_item(qesd_pkg::OP_EDGE_B, clock_us + lag);
                end else begin
                    send_item(qesd_pkg::OP_EDGE_B, clock_us);
                    send_item(qesd_pkg::OP_EDGE_A, clock_us + lag);
                end
                clock_us = clock_us + period;
                if ($urandom_range(0, 3) == 0)
                    send_item(qesd_pkg::OP_QUERY, clock_us - $urandom_range(0, period));
            end
        end else if (pick == 7) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) send_item(qesd_pkg::OP_QUERY, query_time());
        end else if (pick == 8) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                op = 2'($urandom_range(0, 3));
                send_item(op, $urandom_range(0, 1) ? $urandom
                                                   : clock_us + $urandom_range(0, 1000));
            end
        end else begin
            // same channel repeated, no partner edge
            n = $urandom_range(2, 6);
            op = $urandom_range(0, 1) ? qesd_pkg::OP_EDGE_A : qesd_pkg::OP_EDGE_B;
            for (k = 0; k < n; k++) begin
                send_item(op, clock_us);
                clock_us = clock_us + $urandom_range(1, 500);
            end
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(20'd1, 8'd0);
                1: set_config(20'd0, 8'd255);
                2: set_config(20'hFFFFF, 8'($urandom_range(0, 255)));
                3: set_config(20'($urandom_range(50, 2000)), 8'($urandom_range(0, 8)));
                4: set_config(20'($urandom_range(1, 1000000)), 8'($urandom_range(0, 20)));
                default: set_config(qesd_pkg::INTERVAL_RESET, qesd_pkg::THRESHOLD_RESET);
            endcase
            clock_us = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                                   : $urandom;
            target = items_sent + 310;
            while (items_sent < target) drive_traffic_burst();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_direction_filter();
        test_count_saturation();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("quadrature_encoder_speed_direction_core verification clean");
        end else begin
            $display("quadrature_encoder_speed_direction_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/qesd_pkg.sv
rtl/core/qesd_front.sv
rtl/core/qesd_queue.sv
rtl/core/qesd_back.sv
rtl/core/quadrature_encoder_speed_direction_core.sv
bench/tb_top.sv
